// ===== sv/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared constants and controller/datapath interface types for the PSK pulse
// preamble decoder.
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam int WINDOW_BITS = 128;

    localparam logic [31:0] SYNC_WORD   = 32'h4944544B;
    localparam logic [17:0] ROUND_US    = 18'd127;
    localparam logic [17:0] LONG_US     = 18'd16320;
    localparam logic [16:0] PHASE_FIX   = 17'd120;
    localparam logic [15:0] PHASE_MIN   = 16'd120;
    localparam logic [15:0] HALF_US     = 16'd127;
    localparam logic [15:0] QUARTER_US  = 16'd63;
    localparam int          REM_W       = 14;
    localparam logic [REM_W-1:0] US_PER_BIT = 14'd255;

    localparam logic [1:0] PATH_TRUE      = 2'd0;
    localparam logic [1:0] PATH_INV       = 2'd1;
    localparam logic [1:0] PATH_TRUE_SHFT = 2'd2;
    localparam logic [1:0] PATH_INV_SHFT  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       setup;
        logic       push;
        logic       done;
        logic       found;
        logic [1:0] path;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic active;
        logic more;
        logic match;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/psk_pulse_preamble_decoder_top.sv =====
// ----------------------------------------------------------------------------
// psk_pulse_preamble_decoder_top
// PSK pulse preamble decoder: pulses in, preamble search result out.
// ----------------------------------------------------------------------------
// Each input beat on the s_ channel carries one pulse (level and duration in
// microseconds) or, with s_tuser high, a command that zeroes all four shift
// windows. Each input beat yields exactly one output beat on the m_ channel
// with the found flag, the matching window and the held 64-bit word.
// A beat is accepted only when the sequencer is idle. A clear beat goes from
// the setup state, which zeroes the windows, to the finish state. A pulse beat
// visits each window in order: a window that runs gets a setup step, one bit
// push per cycle into the selected window and a closing step; a skipped
// window gets a setup step only. A match ends the search at once, and a
// window takes at most 63 bits per pulse.
// The result sits in an output register, so the next beat is accepted while
// it waits; if the receiver holds m_tready low, the sequencer waits at the
// end of its next item until the output register is free.
// Reset (aresetn low, synchronous) zeroes all windows and the held word and
// drops m_tvalid and s_tready.
// ----------------------------------------------------------------------------
module psk_pulse_preamble_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // level, pulse_us
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // found, path, decoded_word
);

    ppd_pkg::ctrl_cmd_t cmd;
    ppd_pkg::dp_stat_t  stat;

    ppd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppd_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== sv/ppd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppd_ctrl
// Sequencer: walks the four windows in order, one bit push per cycle, stops
// at the first match, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ppd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ppd_pkg::dp_stat_t  stat,
    output ppd_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] path_reg, path_next;
    logic       found_reg, found_next;

    always_comb begin
        state_next = state_reg;
        path_next  = path_reg;
        found_next = found_reg;
        cmd        = '0;
        cmd.path   = path_reg;
        cmd.found  = found_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    path_next  = ppd_pkg::PATH_TRUE;
                    found_next = 1'b0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (stat.is_clear) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_FINISH;
                end else if (stat.active) begin
                    cmd.setup  = 1'b1;
                    state_next = ST_RUN;
                end else if (path_reg == ppd_pkg::PATH_INV_SHFT) begin
                    state_next = ST_FINISH;
                end else begin
                    path_next = path_reg + 2'd1;
                end
            end
            ST_RUN: begin
                if (stat.more) begin
                    cmd.push = 1'b1;
                    if (stat.match) begin
                        found_next = 1'b1;
                        state_next = ST_FINISH;
                    end
                end else if (path_reg == ppd_pkg::PATH_INV_SHFT) begin
                    state_next = ST_FINISH;
                end else begin
                    path_next  = path_reg + 2'd1;
                    state_next = ST_SETUP;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            path_reg  <= ppd_pkg::PATH_TRUE;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            path_reg  <= path_next;
            found_reg <= found_next;
        end
    end

endmodule

// ===== sv/ppd_datapath.sv =====
// ----------------------------------------------------------------------------
// ppd_datapath
// Item register, microsecond remainder down-counter, the four shift windows with the
// preamble compare, the held word and the output register.
// ----------------------------------------------------------------------------
module ppd_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [23:0]        s_tdata,
    input  logic               s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [71:0]        m_tdata,
    input  ppd_pkg::ctrl_cmd_t cmd,
    output ppd_pkg::dp_stat_t  stat
);

    localparam int W = ppd_pkg::WINDOW_BITS;

    logic                      clear_item_reg;
    logic                      level_reg;
    logic [15:0]               dur_reg;
    logic [ppd_pkg::REM_W-1:0] rem_reg;
    logic [W-1:0]              win_reg [4];
    logic [63:0]               held_reg;
    logic                      m_tvalid_reg;
    logic                      out_found_reg;
    logic [1:0]                out_path_reg;
    logic [63:0]               out_word_reg;

    logic [16:0]  dur_ext;
    logic [16:0]  dur_fix;
    logic [16:0]  base_us;
    logic [17:0]  total_us;
    logic         enabled;
    logic         first_pair;
    logic         push_bit;
    logic [W-1:0] win_sel;
    logic [W-1:0] win_shift;
    logic         match;

    assign first_pair = (cmd.path == ppd_pkg::PATH_TRUE) || (cmd.path == ppd_pkg::PATH_INV);
    assign dur_ext    = {1'b0, dur_reg};

    always_comb begin
        if (level_reg) begin
            dur_fix = dur_ext + ppd_pkg::PHASE_FIX;
        end else if (dur_reg > ppd_pkg::PHASE_MIN) begin
            dur_fix = dur_ext - ppd_pkg::PHASE_FIX;
        end else begin
            dur_fix = dur_ext;
        end
    end

    assign base_us  = first_pair ? dur_ext : dur_fix;
    assign total_us = {1'b0, base_us} + ppd_pkg::ROUND_US;
    assign enabled  = first_pair ? (dur_reg > ppd_pkg::HALF_US) : (dur_reg > ppd_pkg::QUARTER_US);

    assign push_bit  = level_reg ^ cmd.path[0];
    assign win_sel   = win_reg[cmd.path];
    assign win_shift = {win_sel[W-2:0], push_bit};
    assign match     = (win_shift[W-1 -: 32] == ppd_pkg::SYNC_WORD);

    assign stat.is_clear = clear_item_reg;
    assign stat.active   = enabled && (total_us < ppd_pkg::LONG_US);
    assign stat.more     = (rem_reg >= ppd_pkg::US_PER_BIT);
    assign stat.match    = match;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clear_item_reg <= s_tuser;
            level_reg      <= s_tdata[0];
            dur_reg        <= s_tdata[16:1];
        end
        if (cmd.setup) begin
            rem_reg <= total_us[ppd_pkg::REM_W-1:0];
        end else if (cmd.push) begin
            rem_reg <= rem_reg - ppd_pkg::US_PER_BIT;
        end
        if (cmd.done) begin
            out_found_reg <= cmd.found;
            out_path_reg  <= cmd.found ? cmd.path : ppd_pkg::PATH_TRUE;
            out_word_reg  <= held_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < 4; p++) begin
                win_reg[p] <= '0;
            end
            held_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                for (int p = 0; p < 4; p++) begin
                    win_reg[p] <= '0;
                end
            end else if (cmd.push) begin
                win_reg[cmd.path] <= win_shift;
                if (match) begin
                    held_reg <= win_shift[W-1 -: 64];
                end
            end
            if (cmd.done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_word_reg, out_path_reg, out_found_reg};

endmodule
